// File: rtl/cdq_pkg.sv
// Package of types, codes and constants for the circular double-ended queue.
package cdq_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int CAP_W     = 8;
    localparam int CAP_RESET = 128;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE       = 2'd0,
        STAT_PUSH_FULL  = 2'd1,
        STAT_POP_EMPTY  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
    } t_cmd;

endpackage

// File: rtl/circular_double_ended_queue_unit.sv
// Top level of the circular double-ended queue: controller and datapath.
//
// Each request passes three steps from its transfer to its result being offered:
// the transfer writes the slot and moves the end indices, the S_READ state then
// reads the front and rear slots through the registered two-port slot store, and
// the S_LOAD state loads the result register. The next request is taken once the
// result register is loaded, while that result may still wait on the output stall,
// so a request is never taken before the last one is through. Writing the capacity
// empties the queue; the slot store needs no clearing after reset.
module circular_double_ended_queue_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [CAP_W-1:0]         i_cfg_wr_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_rear_value,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    t_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_type    (i_req_type),
        .i_push_value  (i_push_value),
        .o_status      (o_status),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full)
    );

endmodule

// File: rtl/cdq_ctrl.sv
// Controller state machine: sequences accept, slot read and result load.
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall       = 1'b1;
        o_cmd.accept  = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_READ: begin
                o_stall = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: rtl/cdq_dpath.sv
// Datapath: slot store, end indices, capacity register and result register.
module cdq_dpath
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_cfg_wr_en,
    input  logic [CAP_W-1:0]         i_cfg_wr_data,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_front_value,
    output logic signed [DATA_W-1:0] o_rear_value,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int EW      = (CW > CAP_W) ? CW : CAP_W;
    localparam int CAP_RST = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;

    logic [DATA_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]     r_cap;
    logic [CW-1:0]     n_cap;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     n_head;
    logic [AW-1:0]     r_tail;
    logic [AW-1:0]     n_tail;
    logic              r_empty;
    logic              n_empty;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;

    logic              w_en;
    logic [AW-1:0]     w_addr;

    logic [DATA_W-1:0] r_front_rd;
    logic [DATA_W-1:0] r_rear_rd;

    logic [STAT_W-1:0]        r_o_status;
    logic signed [DATA_W-1:0] r_o_front;
    logic signed [DATA_W-1:0] r_o_rear;
    logic                     r_o_empty;
    logic                     r_o_full;

    logic [AW-1:0] head_inc;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] tail_dec;
    logic [AW-1:0] cap_last;
    logic          full_now;
    t_req          req;

    assign req      = t_req'(i_req_type);
    assign cap_last = AW'(r_cap - CW'(1));
    assign head_inc = (CW'(CW'(r_head) + CW'(1)) >= r_cap) ? '0 : AW'(r_head + AW'(1));
    assign tail_inc = (CW'(CW'(r_tail) + CW'(1)) >= r_cap) ? '0 : AW'(r_tail + AW'(1));
    assign head_dec = (r_head == '0) ? cap_last : AW'(r_head - AW'(1));
    assign tail_dec = (r_tail == '0) ? cap_last : AW'(r_tail - AW'(1));
    assign full_now = !r_empty && (tail_inc == r_head);

    // clamp the written capacity into one to DEPTH
    always_comb begin
        n_cap = r_cap;
        if (i_cfg_wr_en) begin
            if (i_cfg_wr_data == '0) begin
                n_cap = CW'(1);
            end else if (EW'(i_cfg_wr_data) > EW'(DEPTH)) begin
                n_cap = CW'(DEPTH);
            end else begin
                n_cap = CW'(i_cfg_wr_data);
            end
        end
    end

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = r_status;
        w_en     = 1'b0;
        w_addr   = '0;
        if (i_cfg_wr_en) begin
            n_head  = '0;
            n_tail  = '0;
            n_empty = 1'b1;
        end else if (i_cmd.accept) begin
            n_status = STAT_DONE;
            case (req)
                REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                    if (full_now) begin
                        n_status = STAT_PUSH_FULL;
                    end else if (r_empty) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_empty = 1'b0;
                        w_en    = 1'b1;
                        w_addr  = '0;
                    end else if (req == REQ_PUSH_FRONT) begin
                        n_head = head_dec;
                        w_en   = 1'b1;
                        w_addr = head_dec;
                    end else begin
                        n_tail = tail_inc;
                        w_en   = 1'b1;
                        w_addr = tail_inc;
                    end
                end
                REQ_POP_FRONT, REQ_POP_REAR: begin
                    if (r_empty) begin
                        n_status = STAT_POP_EMPTY;
                    end else if (r_head == r_tail) begin
                        n_empty = 1'b1;
                        n_head  = '0;
                        n_tail  = '0;
                    end else if (req == REQ_POP_FRONT) begin
                        n_head = head_inc;
                    end else begin
                        n_tail = tail_dec;
                    end
                end
                default: begin
                    n_status = STAT_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CW'(CAP_RST);
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else begin
            r_cap   <= n_cap;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= i_push_value;
        end
        r_front_rd <= r_mem[r_head];
        r_rear_rd  <= r_mem[r_tail];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status <= r_status;
            r_o_empty  <= r_empty;
            r_o_full   <= full_now;
            r_o_front  <= r_empty ? '1 : r_front_rd;
            r_o_rear   <= r_empty ? '1 : r_rear_rd;
        end
    end

    assign o_status      = r_o_status;
    assign o_front_value = r_o_front;
    assign o_rear_value  = r_o_rear;
    assign o_is_empty    = r_o_empty;
    assign o_is_full     = r_o_full;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_head) < r_cap) && (CW'(r_tail) < r_cap))
        else $error("queue index beyond capacity");

    a_empty_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("empty queue with non-zero index");

    a_full_push_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && !i_cfg_wr_en && !i_req_type[1] && full_now)
        |=> ($stable(r_head) && $stable(r_tail) && r_status == STAT_PUSH_FULL))
        else $error("push into full queue moved an index");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && r_empty) |=> (r_o_front == '1 && r_o_rear == '1 && !r_o_full))
        else $error("empty result without all-ones ends");

endmodule
